/* hw/rtl/btll_pkg.sv */
`default_nettype none

package btll_pkg;

  // Register map, word index on the configuration port
  localparam logic [1:0] REG_STEP_NOW       = 2'd0;
  localparam logic [1:0] REG_LEVEL_DIFF_MAX = 2'd1;
  localparam logic [1:0] REG_BASE_LEVEL     = 2'd2;

  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned LEVEL_W = 5;
  localparam int unsigned LEN_W   = 32;
  localparam int unsigned SHOWN_W = 24;

  localparam logic [SHOWN_W-1:0] SHOWN_MAX = '1;

  localparam logic [LEVEL_W-1:0] LEVEL_DIFF_MAX_RST = 5'd1;

  // Item action codes carried on s_tuser
  localparam logic ACT_REFRESH = 1'b0;
  localparam logic ACT_CHECK   = 1'b1;

  // Bit positions in status_bits
  localparam int unsigned ST_ACTIVE = 0;
  localparam int unsigned ST_MARK   = 1;
  localparam int unsigned ST_DEAD   = 2;

  localparam int unsigned IN_TDATA_W  = 80;
  localparam int unsigned OUT_TDATA_W = 64;

endpackage

`default_nettype wire

/* hw/rtl/block_timestep_level_limiter_core.sv */
`default_nettype none
// An accepted item passes through the input register, then the result register, before
// its result is valid on the result stream.
// Throughput: one item per cycle while the result side does not stall; the single-pass logic
// between the two registers (time subtract, level compare, shift mask) sets that figure.
// Reset (rst, synchronous, active high) empties both stages, clears the sweep tally,
// and loads step_now = 0, gap_limit = 1, base_level = 0.
module block_timestep_level_limiter_core #(
  parameter int unsigned TIME_BITS  = 32,
  parameter int unsigned COUNT_BITS = 24
) (
  input  wire                                 clk,
  input  wire                                 rst,
  // APB-style configuration port
  input  wire                                 psel,
  input  wire                                 penable,
  input  wire                                 pwrite,
  input  wire  [btll_pkg::ADDR_W-1:0]         paddr,
  input  wire  [btll_pkg::DATA_W-1:0]         pwdata,
  output logic [btll_pkg::DATA_W-1:0]         prdata,
  output logic                                pready,
  // Input stream
  input  wire                                 s_tvalid,
  output logic                                s_tready,
  // tdata: step_start[31:0], step_length[63:32], level[68:64],
  //        neighbour_level[73:69], status_bits[76:74], zero fill[79:77]
  input  wire  [btll_pkg::IN_TDATA_W-1:0]     s_tdata,
  // tuser: action
  input  wire                                 s_tuser,
  // tlast: last_particle
  input  wire                                 s_tlast,
  // Result stream
  output logic                                m_tvalid,
  input  wire                                 m_tready,
  // tdata: active_out[0], new_step_length[32:1], new_level[37:33], reduced[38],
  //        reduced_count[62:39], zero fill[63]
  output logic [btll_pkg::OUT_TDATA_W-1:0]    m_tdata,
  // tlast: sweep_done
  output logic                                m_tlast
);
  import btll_pkg::*;

  // Configuration registers
  logic [DATA_W-1:0]  step_now;
  logic [LEVEL_W-1:0] gap_limit;
  logic [LEVEL_W-1:0] base_level;

  logic cfg_write;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_now   <= '0;
      gap_limit  <= LEVEL_DIFF_MAX_RST;
      base_level <= '0;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_STEP_NOW:       step_now   <= pwdata;
        REG_LEVEL_DIFF_MAX: gap_limit  <= pwdata[LEVEL_W-1:0];
        REG_BASE_LEVEL:     base_level <= pwdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_STEP_NOW:       prdata = step_now;
      REG_LEVEL_DIFF_MAX: prdata = DATA_W'(gap_limit);
      REG_BASE_LEVEL:     prdata = DATA_W'(base_level);
      default:            prdata = '0;
    endcase
  end

  // Input register stage
  logic                 in_valid;
  logic                 in_action;
  logic [TIME_BITS-1:0] in_start;
  logic [LEN_W-1:0]     in_len;
  logic [LEVEL_W-1:0]   in_level;
  logic [LEVEL_W-1:0]   in_nlevel;
  logic [2:0]           in_status;
  logic                 in_last;

  // Result register stage
  logic                 out_valid;
  logic                 out_active;
  logic [LEN_W-1:0]     out_len;
  logic [LEVEL_W-1:0]   out_level;
  logic                 out_reduced;
  logic [SHOWN_W-1:0]   out_count;
  logic                 out_last;

  logic [COUNT_BITS-1:0] tally;
  logic [COUNT_BITS-1:0] tally_next;

  logic advance;
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_action <= s_tuser;
      in_start  <= s_tdata[TIME_BITS-1:0];
      in_len    <= s_tdata[63:32];
      in_level  <= s_tdata[68:64];
      in_nlevel <= s_tdata[73:69];
      in_status <= s_tdata[76:74];
      in_last   <= s_tlast;
    end
  end

  // Single-pass scheduling logic
  logic [TIME_BITS-1:0] dn;
  logic [TIME_BITS-1:0] dn_mask;
  logic                 ended;
  logic                 too_fine;
  logic [LEVEL_W-1:0]   finer_level;
  logic [LEVEL_W-1:0]   shift;
  logic                 shift_ok;
  logic                 synced;
  logic                 do_reduce;
  logic                 active_c;
  logic [LEN_W-1:0]     len_c;
  logic [LEVEL_W-1:0]   level_c;
  logic [COUNT_BITS-1:0] tally_inc;
  logic [31:0]          tally_wide;
  logic [SHOWN_W-1:0]   shown_c;

  assign dn    = step_now[TIME_BITS-1:0] - in_start;
  assign ended = (LEN_W'(dn) == in_len);

  // Neighbours finer than allowed: nlevel - level > gap_limit
  assign too_fine    = ({1'b0, in_level} + {1'b0, gap_limit}) < {1'b0, in_nlevel};
  assign finer_level = in_nlevel - gap_limit;
  assign shift_ok    = (base_level >= finer_level);
  assign shift       = base_level - finer_level;

  always_comb begin
    for (int i = 0; i < TIME_BITS; i++) begin
      dn_mask[i] = (6'(i) < {1'b0, shift});
    end
  end

  assign synced    = ((dn & dn_mask) == '0);
  assign do_reduce = (in_action == ACT_CHECK) && !in_status[ST_DEAD] && !ended
                     && too_fine && shift_ok && synced;

  always_comb begin
    active_c = in_status[ST_ACTIVE];
    len_c    = in_len;
    level_c  = in_level;
    if (in_action == ACT_REFRESH) begin
      active_c = in_status[ST_MARK] || ended;
    end else if (do_reduce) begin
      active_c = 1'b1;
      level_c  = finer_level;
      if (dn != '0) begin
        len_c = LEN_W'(dn);
      end
    end
  end

  // Saturating tally; the result shows the count after this item
  assign tally_inc  = (do_reduce && (tally != '1)) ? tally + 1'b1 : tally;
  assign tally_wide = 32'(tally_inc);
  assign shown_c    = (tally_wide > 32'(SHOWN_MAX)) ? SHOWN_MAX : tally_wide[SHOWN_W-1:0];
  assign tally_next = in_last ? '0 : tally_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      tally <= '0;
    end else if (advance) begin
      tally <= tally_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_active  <= active_c;
      out_len     <= len_c;
      out_level   <= level_c;
      out_reduced <= do_reduce;
      out_count   <= shown_c;
      out_last    <= in_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tdata  = {1'b0, out_count, out_reduced, out_level, out_len, out_active};

  // A sweep's last item leaves the tally empty
  assert property (@(posedge clk) disable iff (rst) (advance && in_last) |=> (tally == '0))
    else $error("tally not cleared after last item of sweep");

  // A reduced particle is always active
  assert property (@(posedge clk) disable iff (rst) (out_valid && out_reduced) |-> out_active)
    else $error("reduced particle not marked active");

  // Input side stalls only when both stages are full and the output is blocked
  assert property (@(posedge clk) disable iff (rst)
      !s_tready |-> (in_valid && out_valid && !m_tready))
    else $error("input stalled without back pressure");

  // A reduction never coarsens the step level
  assert property (@(posedge clk) disable iff (rst) advance && do_reduce |-> (level_c > in_level))
    else $error("reduction did not move to a finer level");

endmodule

`default_nettype wire

/* test/block_timestep_level_limiter_core_tb.sv */
`timescale 1ns / 100ps

module block_timestep_level_limiter_core_tb;
  import btll_pkg::*;

  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct {
    logic                action;
    logic [LEN_W-1:0]    start;
    logic [LEN_W-1:0]    len;
    logic [LEVEL_W-1:0]  lvl;
    logic [LEVEL_W-1:0]  nlvl;
    logic [2:0]          status;
    logic                sweep_end;
  } particle_t;

  typedef struct {
    logic                active;
    logic [LEN_W-1:0]    len;
    logic [LEVEL_W-1:0]  lvl;
    logic                reduced;
    logic [SHOWN_W-1:0]  count;
    logic                sweep_end;
  } sched_t;

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    psel, penable, pwrite;
  logic [ADDR_W-1:0]       paddr;
  logic [DATA_W-1:0]       pwdata;
  logic [DATA_W-1:0]       prdata;
  logic                    pready;
  logic                    s_tvalid, s_tready, s_tuser, s_tlast;
  logic [IN_TDATA_W-1:0]   s_tdata;
  logic                    m_tvalid, m_tready, m_tlast;
  logic [OUT_TDATA_W-1:0]  m_tdata;

  // shadow copy of the block's registers and sweep tally
  logic [LEN_W-1:0]        cfg_step_now;
  logic [LEVEL_W-1:0]      cfg_ldm;
  logic [LEVEL_W-1:0]      cfg_base;
  logic [SHOWN_W-1:0]      sweep_tally;

  sched_t                  pending_sched[$];
  sched_t                  want, got;
  int unsigned             fail_count = 0;
  bit                      src_jitter = 1'b0;
  bit                      sink_jitter = 1'b0;
  int unsigned             hold_requests = 0;
  int unsigned             hold_served;
  int unsigned             stall_left;

  always #5 clk = ~clk;

  block_timestep_level_limiter_core u_top (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  function automatic particle_t particle(logic action, logic [31:0] start, logic [31:0] len,
                                         logic [4:0] lvl, logic [4:0] nlvl,
                                         logic [2:0] status, logic sweep_end);
    particle_t p;
    p.action    = action;
    p.start     = start;
    p.len       = len;
    p.lvl       = lvl;
    p.nlvl      = nlvl;
    p.status    = status;
    p.sweep_end = sweep_end;
    return p;
  endfunction

  // Work out the scheduler's answer for one particle and advance the tally.
  function automatic sched_t schedule_particle(particle_t p);
    sched_t           r;
    logic [LEN_W-1:0] elapsed;
    logic [LEN_W-1:0] sync_mask;
    int               lvl_i, nlvl_i, ldm_i, base_i, lnew, shift;
    elapsed   = cfg_step_now - p.start;
    lvl_i     = p.lvl;
    nlvl_i    = p.nlvl;
    ldm_i     = cfg_ldm;
    base_i    = cfg_base;
    r.active  = p.status[ST_ACTIVE];
    r.len     = p.len;
    r.lvl     = p.lvl;
    r.reduced = 1'b0;
    if (p.action == ACT_REFRESH) begin
      r.active = p.status[ST_MARK] || (elapsed == p.len);
    end else if (!p.status[ST_DEAD] && elapsed != p.len && nlvl_i - lvl_i > ldm_i) begin
      lnew  = nlvl_i - ldm_i;
      shift = base_i - lnew;
      if (shift >= 0) begin
        sync_mask = (shift >= LEN_W) ? '1 : ((32'd1 << shift) - 32'd1);
        if ((elapsed & sync_mask) == '0) begin
          if (elapsed != '0) r.len = elapsed;
          r.lvl     = LEVEL_W'(lnew);
          r.active  = 1'b1;
          r.reduced = 1'b1;
          if (sweep_tally != SHOWN_MAX) sweep_tally = sweep_tally + 1'b1;
        end
      end
    end
    r.count     = sweep_tally;
    r.sweep_end = p.sweep_end;
    if (p.sweep_end) sweep_tally = '0;
    return r;
  endfunction

  // Mostly particles that can reach a reduction, with refresh items and noise mixed in.
  function automatic particle_t rand_particle();
    particle_t        p;
    logic [LEN_W-1:0] elapsed;
    int               pick, ldm_i, base_i, hi_new, lnew, shift;
    ldm_i       = cfg_ldm;
    base_i      = cfg_base;
    hi_new      = (base_i < 31 - ldm_i) ? base_i : 31 - ldm_i;
    pick        = $urandom_range(0, 99);
    p.action    = ACT_CHECK;
    p.start     = $urandom;
    p.len       = $urandom;
    p.lvl       = LEVEL_W'($urandom);
    p.nlvl      = LEVEL_W'($urandom);
    p.status    = 3'($urandom);
    p.sweep_end = ($urandom_range(0, 15) == 0);
    if (pick < 70 && hi_new >= 1) begin
      lnew    = $urandom_range(1, hi_new);
      shift   = base_i - lnew;
      p.nlvl  = LEVEL_W'(lnew + ldm_i);
      p.lvl   = LEVEL_W'($urandom_range(0, lnew - 1));
      elapsed = $urandom;
      elapsed = elapsed & ~((32'd1 << shift) - 32'd1);
      if ($urandom_range(0, 9) == 0) elapsed = '0;
      else if (shift > 0 && $urandom_range(0, 6) == 0) elapsed[$urandom_range(0, shift - 1)] = 1'b1;
      p.start = cfg_step_now - elapsed;
      p.status[ST_DEAD] = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 9) == 0) p.len = elapsed;
    end else if (pick < 85) begin
      p.action = ACT_REFRESH;
      if ($urandom_range(0, 2) == 0) p.len = cfg_step_now - p.start;
    end else begin
      p.action = 1'($urandom);
    end
    return p;
  endfunction

  function automatic void note_fail(string what, logic [31:0] w, logic [31:0] g);
    if (fail_count < 10) $display("%0t ns: %s expected %h got %h", $time, what, w, g);
    fail_count++;
  endfunction

  // Called at a rising edge; returns at the edge where the item is taken.
  task automatic send_particle(input particle_t p);
    if (src_jitter && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, p.status, p.nlvl, p.lvl, p.len, p.start};
    s_tuser  <= p.action;
    s_tlast  <= p.sweep_end;
    do @(posedge clk); while (s_tready !== 1'b1);
    pending_sched.push_back(schedule_particle(p));
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_sched.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_STEP_NOW:       cfg_step_now = value;
      REG_LEVEL_DIFF_MAX: cfg_ldm      = value[LEVEL_W-1:0];
      REG_BASE_LEVEL:     cfg_base     = value[LEVEL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [31:0] step_now, input logic [4:0] ldm,
                            input logic [4:0] base);
    settle();
    apb_write(REG_STEP_NOW, step_now);
    apb_write(REG_LEVEL_DIFF_MAX, {27'd0, ldm});
    apb_write(REG_BASE_LEVEL, {27'd0, base});
  endtask

  // Runs on reset values: step_now 0, gap limit 1, base_level 0.
  task automatic test_refresh_flag();
    send_particle(particle(ACT_REFRESH, 32'h0, 32'h0, 5'd0, 5'd0, 3'b000, 1'b0));
    send_particle(particle(ACT_REFRESH, 32'h7, 32'h5, 5'd31, 5'd31, 3'b010, 1'b0));
    send_particle(particle(ACT_REFRESH, 32'hFFFF_FFFF, 32'h1, 5'd5, 5'd0, 3'b101, 1'b0));
    send_particle(particle(ACT_REFRESH, 32'h1, 32'hFFFF_FFFF, 5'd0, 5'd31, 3'b001, 1'b0));
    send_particle(particle(ACT_REFRESH, 32'h1234_5678, 32'h0, 5'd0, 5'd0, 3'b101, 1'b1));
    send_particle(particle(ACT_CHECK, 32'h0, 32'h9, 5'd0, 5'd31, 3'b000, 1'b0));
  endtask

  task automatic test_check_passthrough();
    set_config(32'h0000_0100, 5'd2, 5'd10);
    // dead, step ended, gap at the limit, negative shift, off the sync grid, coarser neighbour
    send_particle(particle(ACT_CHECK, 32'h0, 32'h3, 5'd0, 5'd10, 3'b100, 1'b0));
    send_particle(particle(ACT_CHECK, 32'h0, 32'h100, 5'd0, 5'd10, 3'b001, 1'b0));
    send_particle(particle(ACT_CHECK, 32'h0, 32'h7, 5'd3, 5'd5, 3'b000, 1'b0));
    send_particle(particle(ACT_CHECK, 32'h0, 32'h7, 5'd0, 5'd31, 3'b001, 1'b0));
    send_particle(particle(ACT_CHECK, 32'hFFFF_FFFF, 32'h7, 5'd0, 5'd10, 3'b000, 1'b0));
    send_particle(particle(ACT_CHECK, 32'h0, 32'h7, 5'd31, 5'd0, 3'b011, 1'b0));
  endtask

  task automatic test_reduction();
    send_particle(particle(ACT_CHECK, 32'h0, 32'h7, 5'd0, 5'd10, 3'b000, 1'b0));
    send_particle(particle(ACT_CHECK, 32'h100, 32'hFFFF_FFFF, 5'd7, 5'd10, 3'b000, 1'b0));
    send_particle(particle(ACT_CHECK, 32'hFF, 32'h9, 5'd0, 5'd12, 3'b010, 1'b1));
    // tally restarts after the sweep's last particle
    send_particle(particle(ACT_CHECK, 32'h0, 32'h7, 5'd0, 5'd10, 3'b000, 1'b0));
    send_particle(particle(ACT_CHECK, 32'hFFFF_FF00, 32'h0, 5'd0, 5'd12, 3'b011, 1'b1));
  endtask

  task automatic test_config_extremes();
    set_config(32'hFFFF_FFFF, 5'd0, 5'd31);
    send_particle(particle(ACT_CHECK, 32'hBFFF_FFFF, 32'h0, 5'd0, 5'd1, 3'b000, 1'b0));
    send_particle(particle(ACT_CHECK, 32'hBFFF_FFFE, 32'h0, 5'd0, 5'd1, 3'b000, 1'b0));
    send_particle(particle(ACT_CHECK, 32'h0, 32'h0, 5'd30, 5'd31, 3'b000, 1'b1));
    set_config(32'h0, 5'd31, 5'd31);
    send_particle(particle(ACT_CHECK, 32'h0, 32'h5, 5'd0, 5'd31, 3'b000, 1'b1));
  endtask

  task automatic test_random_traffic(input int unsigned n, input bit jitter);
    src_jitter = jitter;
    sink_jitter <= jitter;
    repeat (n) send_particle(rand_particle());
  endtask

  // Hold the result side off while the sender keeps offering items.
  task automatic test_output_stall();
    set_config(32'h0, 5'd0, 5'd31);
    src_jitter = 1'b0;
    hold_requests <= hold_requests + 1;
    repeat (30) send_particle(rand_particle());
    test_random_traffic(270, 1'b1);
  endtask

  // result side: random stall bursts, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready    <= 1'b0;
      stall_left  <= 0;
      hold_served <= 0;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      stall_left  <= HOLD_CYCLES;
      m_tready    <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (sink_jitter && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 11);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1) begin
      if (pending_sched.size() == 0) begin
        note_fail("result with nothing pending", 32'h0, m_tdata[31:0]);
      end else begin
        want = pending_sched.pop_front();
        got.active    = m_tdata[0];
        got.len       = m_tdata[32:1];
        got.lvl       = m_tdata[37:33];
        got.reduced   = m_tdata[38];
        got.count     = m_tdata[62:39];
        got.sweep_end = m_tlast;
        if (got.active !== want.active) note_fail("active_out", want.active, got.active);
        if (got.len !== want.len) note_fail("new_step_length", want.len, got.len);
        if (got.lvl !== want.lvl) note_fail("new_level", want.lvl, got.lvl);
        if (got.reduced !== want.reduced) note_fail("reduced", want.reduced, got.reduced);
        if (got.count !== want.count) note_fail("reduced_count", want.count, got.count);
        if (got.sweep_end !== want.sweep_end) note_fail("sweep_done", want.sweep_end, got.sweep_end);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst          <= 1'b1;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    s_tvalid     <= 1'b0;
    s_tdata      <= '0;
    s_tuser      <= ACT_REFRESH;
    s_tlast      <= 1'b0;
    cfg_step_now = '0;
    cfg_ldm      = LEVEL_DIFF_MAX_RST;
    cfg_base     = '0;
    sweep_tally  = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_refresh_flag();
    test_check_passthrough();
    test_reduction();
    test_config_extremes();
    set_config($urandom, 5'd1, 5'd15);
    test_random_traffic(300, 1'b1);
    test_output_stall();
    set_config($urandom, 5'd31, 5'd0);
    test_random_traffic(150, 1'b1);
    set_config($urandom, 5'($urandom_range(2, 6)), 5'($urandom_range(10, 20)));
    test_random_traffic(150, 1'b1);
    set_config($urandom, 5'($urandom_range(0, 4)), 5'($urandom_range(8, 31)));
    test_random_traffic(300, 1'b0);

    s_tvalid <= 1'b0;
    while (pending_sched.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    fail_count += pending_sched.size();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/btll_pkg.sv
hw/rtl/block_timestep_level_limiter_core.sv
test/block_timestep_level_limiter_core_tb.sv
